### hw/rtl/sha256_pkg.sv
// SHA-256 hasher shared types, constants and round functions
package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // queued work item between front and back
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } t_item;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic t_word ror(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hw/rtl/sha256_front.sv
// Input front end: takes beats and holds them in a short queue for the core
module sha256_front #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  sha256_pkg::t_item     i_item,
    output logic                  o_valid,
    input  logic                  i_take,
    output sha256_pkg::t_item     o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha256_pkg::t_item r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                // clamp counts above four here so the core sees 0..4 only
                r_q[r_wp] <= '{data: i_item.data,
                               count: (i_item.count > 3'd4) ? 3'd4 : i_item.count,
                               last: i_item.last};
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_cnt != '0) else $error("full queue drained without read");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count step");
endmodule

### hw/rtl/sha256_back.sv
// Core: byte packing, padding, 64-round compression and digest output
module sha256_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_take,
    input  sha256_pkg::t_item  i_item,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [31:0]        o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BYTE = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_COMP = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_st, n_st;
    logic [31:0] r_h [8];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [5:0]  r_pos;
    logic [63:0] r_len;
    logic [63:0] r_flen;
    logic [5:0]  r_rnd;
    logic [31:0] r_data;
    logic [2:0]  r_cnt;
    logic        r_last;
    logic        r_fin;   // padding under way
    logic [3:0]  r_plen;  // length bytes emitted
    logic        r_mark;  // 0x80 already placed
    logic [2:0]  r_oi;

    logic [7:0]  pb;
    logic        pb_go;
    logic [31:0] wt, t1, t2, x15, x2;
    logic [3:0]  widx;
    logic [4:0]  sh;

    assign o_take = (r_st == S_IDLE) && i_valid;
    assign o_empty = (r_st != S_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'd7);

    // byte to place this cycle
    always_comb begin
        pb = 8'h00;
        pb_go = 1'b0;
        if (r_st == S_BYTE) begin
            pb = r_data[31:24];
            pb_go = 1'b1;
        end else if (r_st == S_PAD) begin
            pb_go = 1'b1;
            if (!r_mark) pb = sha256_pkg::PAD_MARK;
            else if (r_pos == sha256_pkg::LEN_POS || r_plen != 4'd0)
                pb = r_flen[63:56];
            else pb = 8'h00;
        end
    end

    assign widx = r_pos[5:2];
    assign sh   = {~r_pos[1:0], 3'b000};

    // round logic
    always_comb begin
        x15 = r_w[4'(r_rnd - 6'd15)];
        x2  = r_w[4'(r_rnd - 6'd2)];
        if (r_rnd < 6'd16) wt = r_w[r_rnd[3:0]];
        else wt = r_w[r_rnd[3:0]]
                + (sha256_pkg::ror(x15, 7) ^ sha256_pkg::ror(x15, 18) ^ (x15 >> 3))
                + r_w[4'(r_rnd - 6'd7)]
                + (sha256_pkg::ror(x2, 17) ^ sha256_pkg::ror(x2, 19) ^ (x2 >> 10));
        t1 = r_v[7] + (sha256_pkg::ror(r_v[4], 6) ^ sha256_pkg::ror(r_v[4], 11)
             ^ sha256_pkg::ror(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha256_pkg::round_k(r_rnd) + wt;
        t2 = (sha256_pkg::ror(r_v[0], 2) ^ sha256_pkg::ror(r_v[0], 13)
             ^ sha256_pkg::ror(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid)
                n_st = (i_item.count != 3'd0) ? S_BYTE : (i_item.last ? S_PAD : S_IDLE);
            S_BYTE: begin
                if (r_pos == 6'd63) n_st = S_COMP;
                else if (r_cnt == 3'd1) n_st = r_last ? S_PAD : S_IDLE;
            end
            S_PAD: if (r_pos == 6'd63) n_st = S_COMP;
            S_COMP: if (r_rnd == 6'd63) n_st = S_FOLD;
            S_FOLD: begin
                if (r_fin && r_plen == 4'd8) n_st = S_OUT;
                else if (r_fin) n_st = S_PAD;
                else if (r_cnt != 3'd0) n_st = S_BYTE;
                else n_st = r_last ? S_PAD : S_IDLE;
            end
            S_OUT: if (i_pop && r_oi == 3'd7) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_pos <= '0;
            r_len <= '0;
            r_rnd <= '0;
            r_cnt <= '0;
            r_fin <= 1'b0;
            r_plen <= '0;
            r_mark <= 1'b0;
            r_oi  <= '0;
            r_last <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_hash(3'(i));
        end else begin
            r_st <= n_st;
            if (o_take) begin
                r_data <= i_item.data;
                r_cnt  <= i_item.count;
                r_last <= i_item.last;
                if (i_item.count == 3'd0 && i_item.last) begin
                    r_fin <= 1'b1;
                    r_flen <= r_len;
                end
            end
            if (pb_go) begin
                r_w[widx] <= (r_w[widx] & ~(32'hff << sh)) | ({24'h0, pb} << sh);
                r_pos <= r_pos + 6'd1;
                if (r_st == S_BYTE) begin
                    r_data <= {r_data[23:0], 8'h00};
                    r_cnt  <= r_cnt - 3'd1;
                    r_len  <= r_len + 64'd8;
                    // hold the final length once the last data byte is in
                    if (r_cnt == 3'd1 && r_last) begin
                        r_fin <= 1'b1;
                        r_flen <= r_len + 64'd8;
                    end
                end else begin
                    if (!r_mark) r_mark <= 1'b1;
                    else if (r_pos == sha256_pkg::LEN_POS || r_plen != 4'd0) begin
                        r_plen <= r_plen + 4'd1;
                        r_flen <= {r_flen[55:0], 8'h00};
                    end
                end
                if (r_pos == 6'd63)
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            if (r_st == S_COMP) begin
                r_w[r_rnd[3:0]] <= wt;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_st == S_FOLD)
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            if (r_st == S_OUT && i_pop) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_hash(3'(i));
                    r_pos <= '0;
                    r_len <= '0;
                    r_fin <= 1'b0;
                    r_mark <= 1'b0;
                    r_plen <= '0;
                    r_last <= 1'b0;
                end
            end
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_st == S_IDLE) else $error("took beat while busy");
    a_rnd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_COMP) |-> r_rnd == 6'd0) else $error("round index stray");
    a_out_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |-> r_fin && r_plen == 4'd8) else $error("digest before length");
    a_pos_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |-> r_pos == 6'd0) else $error("block not closed");
endmodule

### hw/rtl/sha256_message_hasher_core.sv
// SHA-256 hasher: beats in, eight digest words out per message. Each input beat
// is taken only while the core is idle, then its valid bytes are packed one per
// cycle. Each full 64-byte block then runs 64 rounds and a fold on the single
// compression round unit. A 4-beat queue in front lets input continue while the
// core is compressing or the digest waits to be popped. The last beat adds
// padding (and possibly a second compression) before the eight digest words
// appear in order, index 0 first.
module sha256_message_hasher_core #(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    sha256_pkg::t_item in_item, q_item;
    logic q_valid, q_take;

    assign in_item = '{data: i_data_word, count: i_byte_count, last: i_last};

    sha256_front #(.DEPTH(QDEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(in_item), .o_valid(q_valid), .i_take(q_take), .o_item(q_item)
    );

    sha256_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_take(q_take),
        .i_item(q_item), .o_empty(empty), .i_pop(pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );
endmodule
